// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; each expects clk in scope, UART_ASSERT also rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define UART_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define UART_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/uart_rb_pkg.sv -----
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Types and constants of the UART register block.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
  localparam int STAT_LVL_W = 7;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int CTRL_W     = 3;

  // Control register bit positions
  localparam int CTRL_STRAP_EN   = 0;
  localparam int CTRL_STRAP_BOOT = 1;
  localparam int CTRL_TX_IRQ_EN  = 2;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_TXREQ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_DATA  = 2'd0,
    REG_STAT  = 2'd1,
    REG_CTRL  = 2'd2,
    REG_COUNT = 2'd3
  } reg_addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    kind_t             kind;
    reg_addr_t         reg_addr;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              strap_enable;
    logic              strap_boot;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // capture the input item
    logic exec;    // apply the item to FIFOs and registers
    logic load;    // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_room;  // output register is free or being drained this cycle
  } dp_sts_t;

endpackage

// ----- design/uart_rb_ram.sv -----
// ----------------------------------------------------------------------------
// uart_rb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uart_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/uart_rb_ctrl.sv -----
// ----------------------------------------------------------------------------
// uart_rb_ctrl
// Sequencer: accept an item, execute it, then hand the result on.
// ----------------------------------------------------------------------------
module uart_rb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uart_rb_pkg::dp_sts_t sts,
  output uart_rb_pkg::dp_cmd_t cmd
);
  import uart_rb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_room) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_FIN: begin
        cmd.load = sts.out_room;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  `include "assert_macros.svh"

  `UART_ASSERT(a_accept_to_exec, (in_valid && !in_stall) |=> (state_r == ST_EXEC), "accept did not start execution")
  `UART_ASSERT(a_exec_to_fin, (state_r == ST_EXEC) |=> (state_r == ST_FIN), "execute lasted more than one cycle")

endmodule

// ----- design/uart_rb_dp.sv -----
// ----------------------------------------------------------------------------
// uart_rb_dp
// Datapath: FIFO RAMs, pointers, levels, flags, control and count registers,
// and the output register.
// ----------------------------------------------------------------------------
module uart_rb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uart_rb_pkg::in_item_t  in_data,
  input  uart_rb_pkg::dp_cmd_t   cmd,
  output uart_rb_pkg::dp_sts_t   sts,
  output logic                   out_valid,
  input  logic                   out_stall,
  output uart_rb_pkg::out_item_t out_data
);
  import uart_rb_pkg::*;

  localparam int SUM_W = LVL_W + 1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] wr_index(input logic [PTR_W-1:0] p,
                                                input logic [LVL_W-1:0] lvl);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(lvl);
    wr_index = (sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(sum - SUM_W'(FIFO_DEPTH))
                                           : PTR_W'(sum);
  endfunction

  in_item_t          item_r;
  logic [PTR_W-1:0]  rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [LVL_W-1:0]  rx_level_r, rx_level_nxt;
  logic [PTR_W-1:0]  tx_rd_ptr_r, tx_rd_ptr_nxt;
  logic [LVL_W-1:0]  tx_level_r, tx_level_nxt;
  logic              busy_r, busy_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  logic [WORD_W-1:0] rd_word_r, rd_word_nxt;
  logic              rd_ram_r, rd_ram_nxt;
  logic              tx_pop_r, tx_pop_nxt;
  logic              tx_ram_r, tx_ram_nxt;
  logic [BYTE_W-1:0] tx_byte_r, tx_byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              rx_full, rx_empty, tx_full, tx_fifo_empty;
  logic              rx_push, rx_pop, tx_push, tx_pop;
  logic [WORD_W-1:0] stat_word;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  assign rx_full       = (rx_level_r == LVL_W'(FIFO_DEPTH));
  assign rx_empty      = (rx_level_r == '0);
  assign tx_full       = (tx_level_r == LVL_W'(FIFO_DEPTH));
  assign tx_fifo_empty = (tx_level_r == '0);

  assign rx_push = cmd.exec && (item_r.kind == KIND_LINE) && !rx_full;
  assign rx_pop  = cmd.exec && (item_r.kind == KIND_READ) &&
                   (item_r.reg_addr == REG_DATA) && !rx_empty;
  assign tx_push = cmd.exec && (item_r.kind == KIND_WRITE) &&
                   (item_r.reg_addr == REG_DATA) && !tx_full;
  assign tx_pop  = cmd.exec && (item_r.kind == KIND_TXREQ) && !tx_fifo_empty;

  assign stat_word = {15'd0, STAT_LVL_W'(tx_level_r), STAT_LVL_W'(rx_level_r),
                      ovf_r, !rx_empty, busy_r || !tx_fifo_empty};

  uart_rb_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_push),
    .waddr (wr_index(rx_rd_ptr_r, rx_level_r)),
    .wdata (item_r.line_byte),
    .raddr (rx_rd_ptr_r),
    .rdata (rx_rdata)
  );

  uart_rb_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_push),
    .waddr (wr_index(tx_rd_ptr_r, tx_level_r)),
    .wdata (item_r.write_data),
    .raddr (tx_rd_ptr_r),
    .rdata (tx_rdata)
  );

  // Execute step: update state and latch the pre-update read value; else capture RAM read data
  always_comb begin
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    rx_level_nxt  = rx_level_r;
    tx_rd_ptr_nxt = tx_rd_ptr_r;
    tx_level_nxt  = tx_level_r;
    busy_nxt      = busy_r;
    ovf_nxt       = ovf_r;
    ctrl_nxt      = ctrl_r;
    count_nxt     = count_r;
    rd_word_nxt   = rd_word_r;
    rd_ram_nxt    = rd_ram_r;
    tx_pop_nxt    = tx_pop_r;
    tx_ram_nxt    = tx_ram_r;
    tx_byte_nxt   = tx_byte_r;
    if (cmd.exec) begin
      rd_word_nxt = '0;
      rd_ram_nxt  = rx_pop;
      tx_pop_nxt  = tx_pop;
      tx_ram_nxt  = tx_pop;
      if (rx_pop) begin
        rx_rd_ptr_nxt = ptr_inc(rx_rd_ptr_r);
        rx_level_nxt  = rx_level_r - LVL_W'(1);
      end
      if (rx_push) rx_level_nxt = rx_level_r + LVL_W'(1);
      if (tx_push) tx_level_nxt = tx_level_r + LVL_W'(1);
      if (tx_pop) begin
        tx_rd_ptr_nxt = ptr_inc(tx_rd_ptr_r);
        tx_level_nxt  = tx_level_r - LVL_W'(1);
      end
      case (item_r.kind)
        KIND_READ: begin
          case (item_r.reg_addr)
            REG_STAT: begin
              rd_word_nxt = stat_word;
              ovf_nxt     = 1'b0;
            end
            REG_CTRL:  rd_word_nxt = WORD_W'(ctrl_r);
            REG_COUNT: rd_word_nxt = count_r;
            default:   rd_word_nxt = '0;
          endcase
        end
        KIND_WRITE: begin
          if (item_r.reg_addr == REG_CTRL) ctrl_nxt = item_r.write_data[CTRL_W-1:0];
        end
        KIND_LINE: begin
          count_nxt = count_r + WORD_W'(1);
          if (rx_full) ovf_nxt = 1'b1;
        end
        KIND_TXREQ: begin
          busy_nxt = !tx_fifo_empty;
        end
        default: begin
          rd_word_nxt = '0;
        end
      endcase
    end else begin
      // Hold the popped bytes: the RAMs read the advanced pointers from here on
      if (rd_ram_r) begin
        rd_word_nxt = WORD_W'(rx_rdata);
        rd_ram_nxt  = 1'b0;
      end
      if (tx_ram_r) begin
        tx_byte_nxt = tx_rdata;
        tx_ram_nxt  = 1'b0;
      end
    end
  end

  // Result assembly from the updated state and the RAM read data
  always_comb begin
    out_nxt              = out_r;
    out_valid_nxt        = out_valid_r && out_stall;
    sts.out_room         = !out_valid_r || !out_stall;
    if (cmd.load) begin
      out_valid_nxt          = 1'b1;
      out_nxt.read_data      = rd_ram_r ? WORD_W'(rx_rdata) : rd_word_r;
      out_nxt.irq            = !rx_empty || (ctrl_r[CTRL_TX_IRQ_EN] && !tx_full);
      out_nxt.tx_valid       = tx_pop_r;
      out_nxt.tx_byte        = tx_pop_r ? (tx_ram_r ? tx_rdata : tx_byte_r) : '0;
      out_nxt.strap_enable   = ctrl_r[CTRL_STRAP_EN];
      out_nxt.strap_boot     = ctrl_r[CTRL_STRAP_BOOT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_rd_ptr_r <= '0;
      rx_level_r  <= '0;
      tx_rd_ptr_r <= '0;
      tx_level_r  <= '0;
      busy_r      <= 1'b0;
      ovf_r       <= 1'b0;
      ctrl_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      rx_level_r  <= rx_level_nxt;
      tx_rd_ptr_r <= tx_rd_ptr_nxt;
      tx_level_r  <= tx_level_nxt;
      busy_r      <= busy_nxt;
      ovf_r       <= ovf_nxt;
      ctrl_r      <= ctrl_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_data;
    rd_word_r <= rd_word_nxt;
    rd_ram_r  <= rd_ram_nxt;
    tx_pop_r  <= tx_pop_nxt;
    tx_ram_r  <= tx_ram_nxt;
    tx_byte_r <= tx_byte_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `include "assert_macros.svh"

  `UART_ASSERT(a_rx_level_max, rx_level_r <= LVL_W'(FIFO_DEPTH), "receive level above depth")
  `UART_ASSERT(a_tx_level_max, tx_level_r <= LVL_W'(FIFO_DEPTH), "transmit level above depth")
  `UART_ASSERT(a_no_overwrite, (out_valid_r && out_stall) |-> !cmd.load, "held result overwritten")

endmodule

// ----- design/fifo_uart_register_block_top.sv -----
// ----------------------------------------------------------------------------
// fifo_uart_register_block_top
// UART register block: DATA/STAT/CTRL/COUNT registers over 64-byte rx/tx FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one event per transfer:
//   a bus read, a bus write, a byte arriving from the line, or the transmitter
//   asking for its next byte. Every event yields exactly one result on the
//   output channel (out_valid / out_stall / out_data): read data, irq level,
//   the popped transmit byte, and the two strap pins.
//   After the input transfer the event is executed, then the output register
//   is loaded and out_valid rises. Events are taken one at a time by the
//   sequencer (capture, execute, load), which waits for the registered read
//   of the FIFO RAMs before the next event is taken.
//   The output register parts the two sides: the next event is accepted while
//   a finished result still waits. If the receiver stalls, the result holds
//   and the sequencer waits in its final step until the register frees.
//   Reset (rst_n low, synchronous) empties both FIFOs, clears flags, control
//   bits and the receive count, and drops any pending result. FIFO contents
//   are not cleared; empty entries are never read.
// ----------------------------------------------------------------------------
module fifo_uart_register_block_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  uart_rb_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output uart_rb_pkg::out_item_t out_data
);
  import uart_rb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: one event at a time through capture, execute and result load
  uart_rb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: FIFOs, register file and output register
  uart_rb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/uart_rb_checker.sv -----
// ----------------------------------------------------------------------------
// uart_rb_checker
// Watches both channels of the UART register block, predicts every result
// from the accepted events and compares it field by field.
// ----------------------------------------------------------------------------
module uart_rb_checker
  import uart_rb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  // Shadow copy of the register block state
  logic [BYTE_W-1:0] rx_buf [FIFO_DEPTH];
  logic [PTR_W-1:0]  rx_head;
  logic [LVL_W-1:0]  rx_count;
  logic [BYTE_W-1:0] tx_buf [FIFO_DEPTH];
  logic [PTR_W-1:0]  tx_head;
  logic [LVL_W-1:0]  tx_count;
  logic              shifter_busy;
  logic              ovf_sticky;
  logic [CTRL_W-1:0] ctrl;
  logic [WORD_W-1:0] rx_total;

  out_item_t replies_due[$];
  int        n_bad = 0;

  // Apply one event to the shadow state and return the reply it yields.
  function automatic out_item_t predict_reply(in_item_t ev);
    out_item_t r;
    int        slot;
    r = '0;
    case (ev.kind)
      KIND_READ: begin
        case (ev.reg_addr)
          REG_DATA: begin
            if (rx_count != 0) begin
              r.read_data = WORD_W'(rx_buf[rx_head]);
              rx_head     = PTR_W'((int'(rx_head) + 1) % FIFO_DEPTH);
              rx_count    = rx_count - 1'b1;
            end
          end
          REG_STAT: begin
            r.read_data[0] = shifter_busy || (tx_count != 0);
            r.read_data[1] = (rx_count != 0);
            r.read_data[2] = ovf_sticky;
            r.read_data[3 +: STAT_LVL_W]  = STAT_LVL_W'(rx_count);
            r.read_data[10 +: STAT_LVL_W] = STAT_LVL_W'(tx_count);
            ovf_sticky = 1'b0;
          end
          REG_CTRL: r.read_data = WORD_W'(ctrl);
          default:  r.read_data = rx_total;
        endcase
      end
      KIND_WRITE: begin
        if (ev.reg_addr == REG_DATA) begin
          // drop the byte when the transmit FIFO is full
          if (tx_count < FIFO_DEPTH) begin
            slot         = (int'(tx_head) + int'(tx_count)) % FIFO_DEPTH;
            tx_buf[slot] = ev.write_data;
            tx_count     = tx_count + 1'b1;
          end
        end else if (ev.reg_addr == REG_CTRL) begin
          ctrl = ev.write_data[CTRL_W-1:0];
        end
      end
      KIND_LINE: begin
        rx_total = rx_total + 1'b1;
        if (rx_count < FIFO_DEPTH) begin
          slot         = (int'(rx_head) + int'(rx_count)) % FIFO_DEPTH;
          rx_buf[slot] = ev.line_byte;
          rx_count     = rx_count + 1'b1;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      default: begin
        if (tx_count != 0) begin
          r.tx_byte    = tx_buf[tx_head];
          r.tx_valid   = 1'b1;
          tx_head      = PTR_W'((int'(tx_head) + 1) % FIFO_DEPTH);
          tx_count     = tx_count - 1'b1;
          shifter_busy = 1'b1;
        end else begin
          shifter_busy = 1'b0;
        end
      end
    endcase
    r.irq = (rx_count != 0) || (ctrl[CTRL_TX_IRQ_EN] && (tx_count < FIFO_DEPTH));
    r.strap_enable = ctrl[CTRL_STRAP_EN];
    r.strap_boot   = ctrl[CTRL_STRAP_BOOT];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      rx_head      = '0;
      rx_count     = '0;
      tx_head      = '0;
      tx_count     = '0;
      shifter_busy = 1'b0;
      ovf_sticky   = 1'b0;
      ctrl         = '0;
      rx_total     = '0;
      replies_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(predict_reply(in_data));
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result with no event pending: %p", out_data);
          n_bad++;
        end else begin
          want = replies_due.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, out_data.read_data);
            n_bad++;
          end
          if (out_data.irq !== want.irq) begin
            $error("irq: expected %0b, actual %0b", want.irq, out_data.irq);
            n_bad++;
          end
          if (out_data.tx_valid !== want.tx_valid) begin
            $error("tx_valid: expected %0b, actual %0b", want.tx_valid, out_data.tx_valid);
            n_bad++;
          end
          if (out_data.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %0h, actual %0h", want.tx_byte, out_data.tx_byte);
            n_bad++;
          end
          if (out_data.strap_enable !== want.strap_enable) begin
            $error("strap_enable: expected %0b, actual %0b",
                   want.strap_enable, out_data.strap_enable);
            n_bad++;
          end
          if (out_data.strap_boot !== want.strap_boot) begin
            $error("strap_boot: expected %0b, actual %0b",
                   want.strap_boot, out_data.strap_boot);
            n_bad++;
          end
        end
      end
    end
    fail_count <= n_bad;
    pending    <= replies_due.size();
  end

endmodule

// ----- sim/fifo_uart_register_block_top_test.sv -----
// ----------------------------------------------------------------------------
// fifo_uart_register_block_top_test
// Drives bus accesses and line events into the UART register block, stalls
// the result side at random and with one long hold-off, and reports the
// verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module fifo_uart_register_block_top_test;
  import uart_rb_pkg::*;

  localparam int HOLD_CYCLES = 300;      // long receiver hold-off
  localparam int RANDOM_PER_PHASE = 490; // random events in each phase

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;

  // Percent of cycles in which each side idles; changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Flip to ask the receiver process for one long hold-off
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always #2 clk = ~clk;

  fifo_uart_register_block_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  uart_rb_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: hold off for a long stretch on request, else stall at random.
  always @(posedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_item_t make_event(kind_t k, reg_addr_t a,
                                          logic [BYTE_W-1:0] wd, logic [BYTE_W-1:0] lb);
    in_item_t e;
    e.kind       = k;
    e.reg_addr   = a;
    e.write_data = wd;
    e.line_byte  = lb;
    return e;
  endfunction

  // Fully random event; bursts below may override kind and address.
  function automatic in_item_t rand_event();
    return make_event(kind_t'($urandom_range(3)), reg_addr_t'($urandom_range(3)),
                      BYTE_W'($urandom), BYTE_W'($urandom));
  endfunction

  // Offer one event and hold it until the block takes the transfer.
  // Called and returning at a rising edge.
  task automatic send_event(in_item_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random traffic shaped as bursts: fill and drain each FIFO past its
  // limits so overflow, dropped writes and empty pops all occur, mixed with
  // control writes and plain noise.
  task automatic send_random(int n);
    int       done;
    int       pick;
    int       len;
    in_item_t e;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(9);
      len  = $urandom_range(8, 80);
      for (int i = 0; i < len && done < n; i++) begin
        e = rand_event();
        case (pick)
          0, 1: begin
            // line arrivals, with an occasional status peek
            if ($urandom_range(7) == 0) begin
              e.kind     = KIND_READ;
              e.reg_addr = REG_STAT;
            end else begin
              e.kind = KIND_LINE;
            end
          end
          2, 3: begin
            // drain the receive side, sometimes reading a random register
            e.kind     = KIND_READ;
            e.reg_addr = ($urandom_range(5) == 0) ? reg_addr_t'($urandom_range(3)) : REG_DATA;
          end
          4: begin
            e.kind     = KIND_WRITE;
            e.reg_addr = REG_DATA;
          end
          5: begin
            e.kind = KIND_TXREQ;
          end
          6: begin
            e.kind     = KIND_WRITE;
            e.reg_addr = REG_CTRL;
            i          = len;
          end
          default: begin
            if (i >= 20) i = len;
          end
        endcase
        if (i <= len) begin
          send_event(e);
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 63;

    // Directed: reset values, empty pops, control masking, both FIFOs at
    // byte extremes, ignored register writes.
    send_event(make_event(KIND_READ,  REG_DATA,  8'h00, 8'h00));
    send_event(make_event(KIND_READ,  REG_STAT,  8'hff, 8'hff));
    send_event(make_event(KIND_READ,  REG_CTRL,  8'h00, 8'h00));
    send_event(make_event(KIND_READ,  REG_COUNT, 8'hff, 8'hff));
    send_event(make_event(KIND_TXREQ, REG_DATA,  8'h00, 8'h00));
    send_event(make_event(KIND_WRITE, REG_CTRL,  8'hff, 8'h00));
    send_event(make_event(KIND_READ,  REG_CTRL,  8'h00, 8'h00));
    send_event(make_event(KIND_WRITE, REG_CTRL,  8'h04, 8'hff));
    send_event(make_event(KIND_WRITE, REG_DATA,  8'h00, 8'hff));
    send_event(make_event(KIND_WRITE, REG_DATA,  8'hff, 8'h00));
    send_event(make_event(KIND_READ,  REG_STAT,  8'h00, 8'h00));
    send_event(make_event(KIND_TXREQ, REG_STAT,  8'hff, 8'hff));
    send_event(make_event(KIND_READ,  REG_STAT,  8'h00, 8'h00));
    send_event(make_event(KIND_TXREQ, REG_COUNT, 8'h00, 8'h00));
    send_event(make_event(KIND_TXREQ, REG_CTRL,  8'hff, 8'hff));
    send_event(make_event(KIND_LINE,  REG_DATA,  8'hff, 8'h00));
    send_event(make_event(KIND_LINE,  REG_COUNT, 8'h00, 8'hff));
    send_event(make_event(KIND_WRITE, REG_STAT,  8'hff, 8'hff));
    send_event(make_event(KIND_WRITE, REG_COUNT, 8'hff, 8'hff));
    send_event(make_event(KIND_READ,  REG_STAT,  8'h00, 8'h00));
    send_event(make_event(KIND_READ,  REG_DATA,  8'h00, 8'h00));
    send_event(make_event(KIND_READ,  REG_DATA,  8'h00, 8'h00));
    send_event(make_event(KIND_READ,  REG_DATA,  8'h00, 8'h00));
    send_event(make_event(KIND_READ,  REG_COUNT, 8'h00, 8'h00));
    send_event(make_event(KIND_WRITE, REG_CTRL,  8'h00, 8'h00));

    // Phase one: sender idles lightly, receiver heavily
    send_random(RANDOM_PER_PHASE);

    // Phase two: the other way round
    send_idle_pct = 63;
    recv_idle_pct = 25;
    send_random(RANDOM_PER_PHASE);

    // Phase three: no idling; start with a long receiver hold-off so the
    // block backs up and stalls its input while events keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_flip <= ~hold_flip;
    send_random(RANDOM_PER_PHASE);

    // Drain: wait for every expected result, then let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
